>>> src/add_with_carry_alu_8_16_bcd_core_macros.svh
// Assertion macros used by the add-with-carry ALU top level
`ifndef ADD_WITH_CARRY_ALU_8_16_BCD_CORE_MACROS_SVH
`define ADD_WITH_CARRY_ALU_8_16_BCD_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ADCBCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adcbcd assertion failed");
// Next-cycle implication, disabled during reset
`define ADCBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adcbcd assertion failed");
`else
`define ADCBCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ADCBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/adcbcd_pkg.sv
// Types and constants for the add-with-carry ALU
package adcbcd_pkg;

    localparam int unsigned WordW   = 16;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned NibW    = 4;
    localparam int unsigned Digits  = WordW / NibW;
    localparam int unsigned InDataW = 40;
    localparam int unsigned InUserW = 2;
    localparam int unsigned OutDataW = 24;
    localparam logic [NibW:0] DecMax = 5'd9;
    localparam logic [NibW:0] DecAdj = 5'd6;

    // One operation as captured from the input stream
    typedef struct packed {
        logic [WordW-1:0] accumulator;
        logic [WordW-1:0] operand_value;
        logic             carry_in;
        logic             decimal_mode;
        logic             wide_mode;
    } adc_op_t;

    // One result with its flags
    typedef struct packed {
        logic [WordW-1:0] new_accumulator;
        logic             negative_flag;
        logic             overflow_flag;
        logic             zero_flag;
        logic             carry_out;
    } adc_res_t;

endpackage

>>> src/adcbcd_adder.sv
// Binary and packed BCD adder with N, V, Z and C flags, 8- or 16-bit
module adcbcd_adder (
    input  adcbcd_pkg::adc_op_t  op,
    output adcbcd_pkg::adc_res_t res
);
    import adcbcd_pkg::*;

    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW:0]   bin_sum;
    logic [WordW-1:0] dec_sum;
    logic [Digits:0]  dec_c;
    logic [WordW-1:0] r;
    logic             cout;
    logic [WordW-1:0] vvec;

    // Mask both operands to the selected width
    assign a = op.wide_mode ? op.accumulator : {{ByteW{1'b0}}, op.accumulator[ByteW-1:0]};
    assign b = op.wide_mode ? op.operand_value
                            : {{ByteW{1'b0}}, op.operand_value[ByteW-1:0]};

    // Binary sum
    assign bin_sum = {1'b0, a} + {1'b0, b} + {{WordW{1'b0}}, op.carry_in};

    // Ripple decimal carry through each digit
    always_comb
    begin
        logic [NibW:0] t;
        dec_c[0] = op.carry_in;
        dec_sum  = '0;
        for (int i = 0; i < Digits; i++)
        begin
            t = {1'b0, a[i*NibW +: NibW]} + {1'b0, b[i*NibW +: NibW]}
                + {{NibW{1'b0}}, dec_c[i]};
            if (t > DecMax)
            begin
                dec_sum[i*NibW +: NibW] = t[NibW-1:0] + DecAdj[NibW-1:0];
                dec_c[i+1] = 1'b1;
            end
            else
            begin
                dec_sum[i*NibW +: NibW] = t[NibW-1:0];
                dec_c[i+1] = 1'b0;
            end
        end
    end

    // Select result and carry at the active width
    always_comb
    begin
        if (op.decimal_mode)
        begin
            r    = op.wide_mode ? dec_sum : {{ByteW{1'b0}}, dec_sum[ByteW-1:0]};
            cout = op.wide_mode ? dec_c[Digits] : dec_c[ByteW/NibW];
        end
        else
        begin
            r    = op.wide_mode ? bin_sum[WordW-1:0]
                                : {{ByteW{1'b0}}, bin_sum[ByteW-1:0]};
            cout = op.wide_mode ? bin_sum[WordW] : bin_sum[ByteW];
        end
    end

    // Flags from the final result
    assign vvec = ~(a ^ b) & (a ^ r);

    always_comb
    begin
        res.new_accumulator = op.wide_mode ? r
                                           : {op.accumulator[WordW-1:ByteW], r[ByteW-1:0]};
        res.negative_flag   = op.wide_mode ? r[WordW-1] : r[ByteW-1];
        res.overflow_flag   = op.wide_mode ? vvec[WordW-1] : vvec[ByteW-1];
        res.zero_flag       = (r == '0);
        res.carry_out       = cout;
    end

endmodule

>>> src/add_with_carry_alu_8_16_bcd_core.sv
// Add-with-carry ALU, 8/16-bit, binary or BCD: top level with stream ports
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while m_tready is held high; the adder is a single combinational pass.
// Ready propagates from the result register back through the input register.
// Reset (rst_n low, asynchronous) empties both stages; payload is not reset.
`include "add_with_carry_alu_8_16_bcd_core_macros.svh"
module add_with_carry_alu_8_16_bcd_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // accumulator[15:0], operand_value[31:16], carry_in[32], zero pad[39:33]
    input  logic [adcbcd_pkg::InDataW-1:0]     s_tdata,
    // decimal_mode[0], wide_mode[1]
    input  logic [adcbcd_pkg::InUserW-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // new_accumulator[15:0], negative_flag[16], overflow_flag[17],
    // zero_flag[18], carry_out[19], zero pad[23:20]
    output logic [adcbcd_pkg::OutDataW-1:0]    m_tdata
);
    import adcbcd_pkg::*;

    logic     in_valid_reg;
    adc_op_t  in_op_reg;
    adc_op_t  in_op_next;
    logic     out_valid_reg;
    adc_res_t out_res_reg;
    adc_res_t add_res;
    logic     in_adv;

    // Unpack the input item
    always_comb
    begin
        in_op_next.accumulator   = s_tdata[WordW-1:0];
        in_op_next.operand_value = s_tdata[2*WordW-1:WordW];
        in_op_next.carry_in      = s_tdata[2*WordW];
        in_op_next.decimal_mode  = s_tuser[0];
        in_op_next.wide_mode     = s_tuser[1];
    end

    // Advance when the result register is free or being drained
    assign in_adv   = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || in_adv;

    // Hold the captured item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg <= in_op_next;
        end
    end

    adcbcd_adder u_adder (
        .op  (in_op_reg),
        .res (add_res)
    );

    // Hold the finished result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_adv)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid_reg)
        begin
            out_res_reg <= add_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW - WordW - 4){1'b0}},
                       out_res_reg.carry_out, out_res_reg.zero_flag,
                       out_res_reg.overflow_flag, out_res_reg.negative_flag,
                       out_res_reg.new_accumulator};

    // Checks
    `ADCBCD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !in_adv, in_valid_reg)
    `ADCBCD_ASSERT_NEXT(a_drain, clk, rst_n, m_tvalid && m_tready && !in_valid_reg, !m_tvalid)
    `ADCBCD_ASSERT_IMPL(a_zero, clk, rst_n, m_tvalid && m_tdata[WordW+2], m_tdata[ByteW-1:0] == '0)

endmodule

>>> tb/adc_result_checker.sv
// Checker for the add-with-carry ALU: predicts each result and compares it
`timescale 1ns / 100ps
module adc_result_checker (
    input  logic                            clk,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // accumulator[15:0], operand_value[31:16], carry_in[32], zero pad[39:33]
    input  logic [adcbcd_pkg::InDataW-1:0]  s_tdata,
    // decimal_mode[0], wide_mode[1]
    input  logic [adcbcd_pkg::InUserW-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // new_accumulator[15:0], negative_flag[16], overflow_flag[17],
    // zero_flag[18], carry_out[19], zero pad[23:20]
    input  logic [adcbcd_pkg::OutDataW-1:0] m_tdata,
    output int                              fail_count,
    output int                              pending,
    output int                              checked
);
    import adcbcd_pkg::*;

    localparam logic [5:0] DIGIT_MAX  = 6'd9;
    localparam logic [5:0] DIGIT_ADJ  = 6'd6;

    adc_res_t sums_due[$];
    int       mismatches = 0;
    int       compared = 0;

    // Compute the sum and flags for one item, binary or packed BCD
    function automatic adc_res_t adc_sum(adc_op_t op);
        logic [15:0] mask;
        logic [15:0] sign;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] r;
        logic [16:0] bin_sum;
        logic [5:0]  nib;
        logic        carry;
        int          ndig;
        adc_res_t    res;
        mask  = op.wide_mode ? 16'hffff : 16'h00ff;
        sign  = op.wide_mode ? 16'h8000 : 16'h0080;
        a     = op.accumulator & mask;
        b     = op.operand_value & mask;
        r     = '0;
        carry = op.carry_in;
        if (op.decimal_mode)
        begin
            // ripple the decimal carry digit by digit; digits A..F still adjust
            ndig = op.wide_mode ? 4 : 2;
            for (int i = 0; i < ndig; i++)
            begin
                nib = 6'(a[4*i +: 4]) + 6'(b[4*i +: 4]) + 6'(carry);
                if (nib > DIGIT_MAX)
                begin
                    nib   = nib + DIGIT_ADJ;
                    carry = 1'b1;
                end
                else
                begin
                    carry = 1'b0;
                end
                r[4*i +: 4] = nib[3:0];
            end
        end
        else
        begin
            bin_sum = 17'(a) + 17'(b) + 17'(op.carry_in);
            carry   = bin_sum > 17'(mask);
            r       = bin_sum[15:0] & mask;
        end
        res.new_accumulator = op.wide_mode ? r : {op.accumulator[15:8], r[7:0]};
        res.negative_flag   = |(r & sign);
        res.overflow_flag   = |(~(a ^ b) & (a ^ r) & sign);
        res.zero_flag       = (r == 16'h0000);
        res.carry_out       = carry;
        return res;
    endfunction

    // Compare one field and count a mismatch
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: result %0d %s mismatch: expected %h, got %h",
                     $time, compared, name, want, got);
        end
    endtask

    // Check results before queuing new items; both can happen on one edge
    always @(posedge clk)
    begin
        adc_op_t  op;
        adc_res_t want;
        if (m_tvalid && m_tready)
        begin
            if (sums_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h",
                         $time, m_tdata);
            end
            else
            begin
                want = sums_due.pop_front();
                check_field("new_accumulator", want.new_accumulator, m_tdata[15:0]);
                check_field("negative_flag", 16'(want.negative_flag), 16'(m_tdata[16]));
                check_field("overflow_flag", 16'(want.overflow_flag), 16'(m_tdata[17]));
                check_field("zero_flag", 16'(want.zero_flag), 16'(m_tdata[18]));
                check_field("carry_out", 16'(want.carry_out), 16'(m_tdata[19]));
            end
            compared++;
        end
        if (s_tvalid && s_tready)
        begin
            op.accumulator   = s_tdata[15:0];
            op.operand_value = s_tdata[31:16];
            op.carry_in      = s_tdata[32];
            op.decimal_mode  = s_tuser[0];
            op.wide_mode     = s_tuser[1];
            sums_due.push_back(adc_sum(op));
        end
        fail_count <= mismatches;
        pending    <= sums_due.size();
        checked    <= compared;
    end

endmodule

>>> tb/tb_add_with_carry_alu_8_16_bcd_core.sv
// Testbench top for the add-with-carry ALU: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_add_with_carry_alu_8_16_bcd_core;
    import adcbcd_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 700;
    localparam int MAX_WAIT     = 11;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata = '0;
    logic [InUserW-1:0]    s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OutDataW-1:0]   m_tdata;

    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    int quiet_cycles = 0;
    int src_left = 0;
    bit src_calm = 1'b0;
    int snk_left = 0;
    bit snk_calm = 1'b0;

    add_with_carry_alu_8_16_bcd_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    adc_result_checker checker_i (
        .clk        (clk),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Draw a wait; stretches of random waits are mixed at random with stretches of none
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0)
        begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(10, 40);
        end
        left--;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Pick an operand word: corners, valid BCD digits or raw bits
    function automatic logic [15:0] pick_word(logic bcd);
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 9))
            0: w = 16'h0000;
            1: w = 16'hffff;
            2: w = bcd ? 16'h9999 : 16'h8000;
            3: w = bcd ? 16'h0999 : 16'h7fff;
            default:
            begin
                if (bcd && $urandom_range(0, 4) != 0)
                    for (int i = 0; i < 4; i++)
                        w[4*i +: 4] = 4'($urandom_range(0, 9));
            end
        endcase
        return w;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_add(input logic [15:0] acc, input logic [15:0] opv,
                            input logic cin, input logic dec, input logic wide);
        int gap;
        gap = draw_wait(src_left, src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, cin, opv, acc};
        s_tuser  <= {wide, dec};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: stall a random number of cycles per item
    initial
    begin
        int stall;
        forever
        begin
            stall = draw_wait(snk_left, snk_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results pending",
                     $time, QUIET_LIMIT, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Main stimulus
    initial
    begin
        logic        dec;
        logic        wide;
        logic        cin;
        logic [15:0] acc;
        logic [15:0] opv;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // binary, 8-bit: zero, carry, overflow, high byte passes through
        send_add(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        send_add(16'ha5ff, 16'hff01, 1'b0, 1'b0, 1'b0);
        send_add(16'h5a7f, 16'h0001, 1'b0, 1'b0, 1'b0);
        send_add(16'hff80, 16'h0080, 1'b0, 1'b0, 1'b0);
        send_add(16'h00ff, 16'hffff, 1'b1, 1'b0, 1'b0);
        // binary, 16-bit
        send_add(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
        send_add(16'hffff, 16'h0001, 1'b0, 1'b0, 1'b1);
        send_add(16'h7fff, 16'h0001, 1'b0, 1'b0, 1'b1);
        send_add(16'h8000, 16'h8000, 1'b0, 1'b0, 1'b1);
        send_add(16'hffff, 16'hffff, 1'b1, 1'b0, 1'b1);
        // decimal, 8-bit: digit carry, wrap to zero, invalid digits
        send_add(16'hc309, 16'h0001, 1'b0, 1'b1, 1'b0);
        send_add(16'h0099, 16'h0001, 1'b0, 1'b1, 1'b0);
        send_add(16'h3c45, 16'hff55, 1'b0, 1'b1, 1'b0);
        send_add(16'h000f, 16'h000f, 1'b0, 1'b1, 1'b0);
        send_add(16'hffff, 16'hffff, 1'b1, 1'b1, 1'b0);
        send_add(16'h0079, 16'h0001, 1'b0, 1'b1, 1'b0);
        // decimal, 16-bit: carry rippling through every digit
        send_add(16'h9999, 16'h0001, 1'b0, 1'b1, 1'b1);
        send_add(16'h0999, 16'h0000, 1'b1, 1'b1, 1'b1);
        send_add(16'h9999, 16'h9999, 1'b1, 1'b1, 1'b1);
        send_add(16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1);
        send_add(16'h4999, 16'h5000, 1'b1, 1'b1, 1'b1);
        send_add(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1);
        drain_results();

        // random items, mostly valid BCD in decimal mode
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 200 == 199)
                drain_results();
            dec  = 1'($urandom);
            wide = 1'($urandom);
            cin  = 1'($urandom);
            acc  = pick_word(dec);
            opv  = pick_word(dec);
            send_add(acc, opv, cin, dec, wide);
        end
        drain_results();
        repeat (6) @(posedge clk);

        $display("Sent %0d items: corner and random adds, binary and BCD, 8- and 16-bit,",
                 items_sent);
        $display("with random gaps and stalls on both sides; %0d results compared.", checked);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
